// ----- rtl/modexp_pkg.sv -----
// Package for the modular exponentiation block.
// Holds the fixed field widths, stream packing offsets and the multiplier counter size.
// Used by modexp_mulmod, modular_exponentiation and modexp_checker.
package modexp_pkg;

    // Field widths of one input item and one result item.
    localparam int BASE_W  = 31;
    localparam int EXP_W   = 32;
    localparam int MOD_W   = 31;
    localparam int POWER_W = 31;

    // Input stream packing: base, exponent, modulus from the lowest bit up.
    localparam int BASE_LSB  = 0;
    localparam int EXP_LSB   = BASE_LSB + BASE_W;
    localparam int MOD_LSB   = EXP_LSB + EXP_W;
    localparam int IN_BITS   = MOD_LSB + MOD_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Output stream packing: power in the lowest bits.
    localparam int M_TDATA_W = ((POWER_W + 7) / 8) * 8;

    // The multiplier walks the multiplicand one bit per cycle.
    localparam int CNT_W = $clog2(BASE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BASE_W - 1);

endpackage

// ----- rtl/modular_exponentiation.sv -----
// Top level of the modular exponentiation block: stream ports and the square-and-multiply
// sequencer around one shared modular multiplier. Depends on modexp_pkg and modexp_mulmod.
//
// Usage:
// An item enters on the s_axis channel as base, exponent and modulus; one result, the
// power, leaves on the m_axis channel for every item. The exponent is scanned from its
// least significant bit. The base is first reduced by the modulus, then every remaining
// exponent bit costs one modular square, and a set bit costs one modular multiply before it.
// Each modular multiplication runs through the shared shift-and-subtract unit, which
// steps through the multiplicand bits and then raises done. A multiply hands over to
// its square in the done cycle; after a square the sequencer passes through S_BIT before
// the next start. A zero exponent or a zero modulus skips the multiplier and goes
// straight to S_DONE. One item is in work at a time: s_axis_tready is high only while
// the sequencer is idle. The result sits in an output register, so a new item is taken
// while an earlier result still waits; if the receiver holds m_axis_tready low, the next
// result waits in the sequencer until the register frees up.
// Reset clears the sequencer and the output valid; an item in work or a waiting result
// is dropped.
module modular_exponentiation #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // base [30:0], exponent [62:31], modulus [93:63], zero padding [95:94]
    input  logic [modexp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // power [30:0], zero padding [31]
    output logic [modexp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready
);
    import modexp_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_BIT  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [MOD_BITS-1:0] mod_reg, mod_next;
    logic [MOD_BITS-1:0] base_reg, base_next;
    logic [MOD_BITS-1:0] result_reg, result_next;
    logic                out_valid_reg, out_valid_next;
    logic [POWER_W-1:0]  out_power_reg, out_power_next;

    logic [BASE_W-1:0]   in_base;
    logic [EXP_W-1:0]    in_exponent;
    logic [MOD_W-1:0]    in_modulus;
    logic [MOD_BITS-1:0] in_mod_cut;
    logic [EXP_BITS-1:0] in_exp_cut;
    logic                in_xfer;

    logic                mm_start;
    logic [BASE_W-1:0]   mm_a;
    logic [MOD_BITS-1:0] mm_b;
    logic [MOD_BITS-1:0] mm_product;
    logic                mm_done;

    // Unpack the input item; the exponent and modulus are cut to their parameter widths.
    assign in_base     = s_axis_tdata[BASE_LSB +: BASE_W];
    assign in_exponent = s_axis_tdata[EXP_LSB +: EXP_W];
    assign in_modulus  = s_axis_tdata[MOD_LSB +: MOD_W];
    assign in_mod_cut  = MOD_BITS'(in_modulus);
    assign in_exp_cut  = EXP_BITS'(in_exponent);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Square-and-multiply sequencer; it also picks the operands of the shared multiplier.
    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        base_next      = base_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        out_power_next = out_power_reg;
        mm_start       = 1'b0;
        mm_a           = BASE_W'(base_reg);
        mm_b           = base_reg;

        // The output register empties on a transfer out.
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    exp_next    = in_exp_cut;
                    mod_next    = in_mod_cut;
                    result_next = MOD_BITS'(1);
                    if (in_mod_cut == '0)
                    begin
                        // Nothing can be reduced by a zero modulus: the result is zero.
                        result_next = '0;
                        state_next  = S_DONE;
                    end
                    else if (in_exp_cut == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Reduce the base first as base * 1 mod m.
                        mm_start   = 1'b1;
                        mm_a       = in_base;
                        mm_b       = MOD_BITS'(1);
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                if (mm_done)
                begin
                    base_next  = mm_product;
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_a       = BASE_W'(result_reg);
                    state_next = S_MUL;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (mm_done)
                begin
                    result_next = mm_product;
                    mm_start    = 1'b1;
                    state_next  = S_SQR;
                end
            end
            S_SQR:
            begin
                if (mm_done)
                begin
                    base_next  = mm_product;
                    exp_next   = exp_reg >> 1;
                    state_next = S_BIT;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_power_next = POWER_W'(result_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Shared modular multiplier.
    modexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .a       (mm_a),
        .b       (mm_b),
        .m       (mod_reg),
        .product (mm_product),
        .done    (mm_done)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working values and the output payload.
    always_ff @(posedge clk)
    begin
        exp_reg       <= exp_next;
        mod_reg       <= mod_next;
        base_reg      <= base_next;
        result_reg    <= result_next;
        out_power_reg <= out_power_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_power_reg);

endmodule

// ----- rtl/modexp_mulmod.sv -----
// Interleaved shift-and-subtract modular multiplier, one multiplicand bit per cycle.
// Computes (a * b) mod m for b <= m and m >= 1; depends on modexp_pkg.
module modexp_mulmod #(
    parameter int MOD_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [modexp_pkg::BASE_W-1:0] a,
    input  logic [MOD_BITS-1:0]           b,
    input  logic [MOD_BITS-1:0]           m,
    output logic [MOD_BITS-1:0]           product,
    output logic                          done
);
    import modexp_pkg::*;

    localparam int SUM_W = MOD_BITS + 2;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [BASE_W-1:0]   a_reg, a_next;
    logic [MOD_BITS-1:0] b_reg, b_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m_one;
    logic [SUM_W-1:0] m_two;
    logic [SUM_W-1:0] sum_red;

    // One step: double the accumulator, add b if the multiplicand bit is set,
    // then bring the sum back below m with at most two subtractions.
    always_comb
    begin
        m_one = SUM_W'(m);
        m_two = {1'b0, m, 1'b0};
        sum   = {1'b0, acc_reg, 1'b0} + (a_reg[BASE_W-1] ? SUM_W'(b_reg) : '0);
        if (sum >= m_two)
        begin
            sum_red = sum - m_two;
        end
        else if (sum >= m_one)
        begin
            sum_red = sum - m_one;
        end
        else
        begin
            sum_red = sum;
        end
    end

    // Sequencing of the bit steps.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_LAST;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = sum_red[MOD_BITS-1:0];
            a_next   = {a_reg[BASE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

// ----- rtl/modexp_checker.sv -----
// Port-level checker for the modular exponentiation block, bound to the top level.
// Depends on modexp_pkg and on the port list of modular_exponentiation.
module modexp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic [modexp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [modexp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready
);
    import modexp_pkg::*;

    logic s_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // A waiting result holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

    // One item at a time: no second transfer in right after one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_axis_tready)
    else $error("input taken while an item is still in work");

    // No result appears in the cycle right after a transfer in when none was waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

    // A zero exponent with an odd modulus gives a result of 1, checked when no result was waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && !m_axis_tvalid && (s_axis_tdata[EXP_LSB +: EXP_W] == '0)
            && s_axis_tdata[MOD_LSB]
        |=> ##1 m_axis_tvalid && (m_axis_tdata[POWER_W-1:0] == POWER_W'(1)))
    else $error("zero exponent did not give one");

    // The padding bits of the result stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:POWER_W] == '0))
    else $error("result padding not zero");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for the modular exponentiation block: directed and random stream traffic.
// Depends on modexp_pkg and the modular_exponentiation RTL; checks every power in order.
module testbench;

    import modexp_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int HOLD_CYCLES = 1500;
    localparam int IDLE_LIMIT  = 20000;
    localparam int TAIL_CYCLES = 40;
    localparam int N_RANDOM    = 260;

    localparam logic [BASE_W-1:0] BASE_MAX = '1;
    localparam logic [EXP_W-1:0]  EXP_MAX  = '1;
    localparam logic [MOD_W-1:0]  MOD_MAX  = '1;

    // Scoreboard: computes the expected power of each accepted item and checks results in order.
    class power_tracker;
        logic [POWER_W-1:0] expected_q[$];
        int n_items;
        int n_results;
        int n_errors;

        function bit [POWER_W-1:0] predict_power(bit [BASE_W-1:0] base,
                                                 bit [EXP_W-1:0] exponent,
                                                 bit [MOD_W-1:0] modulus);
            bit [63:0] acc;
            bit [63:0] sq;
            bit [63:0] md;
            md = 64'(modulus);
            // With no modulus there is nothing to reduce by, so the result is zero.
            if (md == '0)
                return '0;
            acc = 64'd1;
            sq  = 64'(base);
            for (int i = 0; i < EXP_W; i++)
            begin
                if (exponent[i])
                    acc = (acc * sq) % md;
                sq = (sq * sq) % md;
            end
            return acc[POWER_W-1:0];
        endfunction

        function void note_item(bit [BASE_W-1:0] base, bit [EXP_W-1:0] exponent,
                                bit [MOD_W-1:0] modulus);
            expected_q.push_back(predict_power(base, exponent, modulus));
            n_items++;
        endfunction

        function void check_power(logic [M_TDATA_W-1:0] tdata);
            logic [POWER_W-1:0] expected;
            logic [POWER_W-1:0] actual;
            actual = tdata[POWER_W-1:0];
            n_results++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual power %0d",
                         $time, actual);
                n_errors++;
                return;
            end
            expected = expected_q.pop_front();
            if (actual !== expected)
            begin
                $display("%0t: power mismatch, expected %0d, actual %0d",
                         $time, expected, actual);
                n_errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;

    power_tracker powers;
    bit           hold_req;
    int           n_holds;
    int           n_zero_exp;
    int           n_full_exp;
    int           tx_burst;
    int           rx_burst;
    int           idle_cycles;

    modular_exponentiation i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Idle cycles before the next transfer; now and then a stretch with no idling at all.
    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst = $urandom_range(5, 20);
        return $urandom_range(0, 19);
    endfunction

    // Offers one item and returns at the falling edge after its transfer, valid still high.
    task automatic send_item(bit [BASE_W-1:0] base, bit [EXP_W-1:0] exponent,
                             bit [MOD_W-1:0] modulus, bit back_to_back);
        logic [S_TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[BASE_LSB +: BASE_W] = base;
        word[EXP_LSB +: EXP_W]   = exponent;
        word[MOD_LSB +: MOD_W]   = modulus;
        gap = back_to_back ? 0 : draw_gap(tx_burst);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        powers.note_item(base, exponent, modulus);
        if (exponent == 0)
            n_zero_exp++;
        if (exponent[EXP_W-1])
            n_full_exp++;
        @(negedge clk);
    endtask

    // Random item; the exponent width is capped so that some phases run short items.
    task automatic send_random(int max_exp_w, bit back_to_back);
        bit [BASE_W-1:0] base;
        bit [EXP_W-1:0]  exponent;
        bit [MOD_W-1:0]  modulus;
        bit [63:0]       mask;
        int              exp_w;
        case ($urandom_range(0, 3))
            0: base = BASE_W'($urandom_range(0, 20));
            1: base = BASE_MAX - BASE_W'($urandom_range(0, 3));
            default: base = BASE_W'($urandom);
        endcase
        exp_w = $urandom_range(0, max_exp_w);
        mask = (64'd1 << exp_w) - 64'd1;
        exponent = $urandom & mask[EXP_W-1:0];
        if (exp_w > 0 && $urandom_range(0, 1))
            exponent[exp_w-1] = 1'b1;
        case ($urandom_range(0, 3))
            0: modulus = MOD_W'($urandom_range(1, 16));
            1: modulus = MOD_W'(1) << $urandom_range(0, MOD_W - 1);
            2: modulus = MOD_MAX - MOD_W'($urandom_range(0, 1000));
            default: modulus = MOD_W'($urandom_range(1, 32'h7FFF_FFFF));
        endcase
        send_item(base, exponent, modulus, back_to_back);
    endtask

    // Lowers valid and waits until every expected power has been returned.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (powers.pending() > 0)
            @(negedge clk);
    endtask

    // Stimulus: reset, directed corners, random traffic with a hold-off and a drain pause.
    initial
    begin
        powers = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero exponent, modulus of one, zero modulus and the field extremes.
        send_item('0, '0, 31'd1, 1'b0);
        send_item(BASE_MAX, '0, MOD_MAX, 1'b0);
        send_item(31'd5, 32'd3, 31'd1, 1'b0);
        send_item('0, '0, '0, 1'b0);
        send_item(31'd12345, 32'd7, '0, 1'b0);
        send_item(BASE_MAX, EXP_MAX, MOD_MAX, 1'b0);
        send_item(BASE_MAX, EXP_MAX, 31'd2, 1'b0);
        send_item('0, 32'd1, MOD_MAX, 1'b0);
        send_item(31'd1, EXP_MAX, 31'd3, 1'b0);
        send_item(31'd2, 32'd30, MOD_MAX, 1'b0);
        send_item(31'd3, 32'h8000_0000, 31'd1000003, 1'b0);
        // Base larger than the modulus goes in unreduced.
        send_item(BASE_MAX, 32'd1, 31'd1000, 1'b0);
        send_item(31'd7, 32'd1, MOD_MAX, 1'b0);
        send_item(31'd97, 32'd5, 31'd97, 1'b0);
        send_item(BASE_MAX - 31'd1, 32'd2, MOD_MAX, 1'b0);
        send_item(31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555, 1'b0);
        send_item(31'h5555_5555, 32'h5555_5555, 31'h2AAA_AAAA, 1'b0);
        send_item(BASE_MAX, '0, 31'd1, 1'b0);
        send_item(31'd1, EXP_MAX, 31'd1, 1'b0);
        send_item(31'd65536, 32'h0000_FFFF, 31'h4000_0000, 1'b1);
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 80)
            begin
                // Receiver stalls for a long stretch while short items keep coming.
                hold_req = 1'b1;
                for (int k = 0; k < 6; k++)
                    send_random(4, 1'b1);
            end
            if (i == 180)
                wait_drained();
            send_random(($urandom_range(0, 3) == 0) ? 8 : EXP_W, 1'b0);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Checked %0d powers from %0d items: %0d with zero exponent, %0d with bit 31 set.",
                 powers.n_results, powers.n_items, n_zero_exp, n_full_exp);
        $display("Receiver held off %0d time(s) for %0d cycles; random gaps on both sides.",
                 n_holds, HOLD_CYCLES);
        if (powers.n_errors == 0 && powers.pending() == 0)
            $display("PASS modular_exponentiation");
        else
            $display("FAIL modular_exponentiation");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request, every transfer checked.
    initial
    begin
        int gap;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                n_holds++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                gap = draw_gap(rx_burst);
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            powers.check_power(m_axis_tdata);
            @(negedge clk);
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL modular_exponentiation");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
